[rtl/core/gbtd_pkg.sv]
// shared constants, types and the cordic angle table of the goertzel tone detector
`timescale 1ns / 1ps
`default_nettype none

package gbtd_pkg;

    localparam int MAX_BLOCK = 4096;
    localparam int BSZ_MIN   = 4;
    localparam int CNT_W     = 13;
    localparam int MAG_W     = 16;
    localparam int PH_W      = 16;
    localparam int CFG_W     = 19;
    localparam int C2_W      = 19;
    localparam int SINE_W    = 18;
    localparam int CORDIC_N  = 15;
    localparam int MUL_W     = 32;

    typedef enum logic [1:0] {
        CFG_BLOCK_SIZE = 2'd0,
        CFG_TWO_COS    = 2'd1,
        CFG_SINE       = 2'd2
    } t_cfg_idx;

    // phase request from the sequencer to the cordic unit
    typedef struct packed {
        logic start;
        logic re_neg;
        logic im_neg;
    } t_ph_req;

    function automatic logic [13:0] atan_step(input logic [3:0] k);
        logic [13:0] a;
        case (k)
            4'd0:    a = 14'd8192;
            4'd1:    a = 14'd4836;
            4'd2:    a = 14'd2555;
            4'd3:    a = 14'd1297;
            4'd4:    a = 14'd651;
            4'd5:    a = 14'd326;
            4'd6:    a = 14'd163;
            4'd7:    a = 14'd81;
            4'd8:    a = 14'd41;
            4'd9:    a = 14'd20;
            4'd10:   a = 14'd10;
            4'd11:   a = 14'd5;
            4'd12:   a = 14'd3;
            4'd13:   a = 14'd1;
            4'd14:   a = 14'd1;
            default: a = 14'd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

[rtl/core/goertzel_block_tone_detector.sv]
// goertzel single-bin tone detector: sequencer, state and result registers
// Each counted sample makes two passes through the shared 32x32 multiplier for the
// split coefficient product, then rounding, saturation and two saturating adds before the
// next transfer. A sample past the block size is dropped. The sample marked last adds
// two more product passes (cosine and sine terms), then the magnitude: two squares and
// a 16-bit search on the same multiplier, each bit a product, a square and a compare,
// while the cordic unit (normalizing, then 15 steps) runs alongside.
// Input ready is low during all of this. A finished result waits in the output
// register and the next sample is taken meanwhile. No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module goertzel_block_tone_detector
    import gbtd_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_BITS    = 48
)
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [1:0]              i_cfg_index,
    input  wire logic [CFG_W-1:0]        i_cfg_data,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                    i_last,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [MAG_W-1:0]             o_magnitude,
    output logic signed [PH_W-1:0]       o_phase,
    output logic [CNT_W-1:0]             o_samples_used,
    output logic                         o_empty_block,
    output logic                         o_overflow
);

    localparam int A      = ACC_BITS;
    localparam int HALF   = (A + 1) / 2;
    localparam int HIW    = A - HALF;
    localparam int FULL_W = A + C2_W;
    localparam int Q_W    = FULL_W + 1 - 16;
    localparam int MSQ_W  = 56;
    localparam logic signed [A+1:0] ACC_HI = $signed({3'b000, {(A-1){1'b1}}});
    localparam logic signed [A+1:0] ACC_LO = $signed({3'b111, {(A-1){1'b0}}});

    typedef enum logic [1:0] {OP_REC, OP_RE, OP_IM} t_op;

    typedef enum logic [4:0] {
        S_IDLE, S_M_LO, S_M_HI, S_M_RND, S_M_SAT, S_ADD_A, S_ADD_B, S_RE_SUB,
        S_IM_ST, S_MAG_CHK, S_SQ_R, S_SQ_I, S_SQ_SUM, S_B_TN, S_B_SQ, S_B_CMP,
        S_PH_WAIT, S_OUT
    } t_state;

    t_state                  r_state;
    t_op                     r_op;
    logic [CNT_W-1:0]        r_bsz;
    logic signed [C2_W-1:0]  r_c2cos;
    logic signed [SINE_W-1:0] r_sine;
    logic signed [A-1:0]     r_s1, r_s2, r_pq, r_re, r_im;
    logic [CNT_W-1:0]        r_count;
    logic                    r_sat;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic                    r_last;
    logic [HALF+C2_W-1:0]    r_plo;
    logic [Q_W-1:0]          r_q;
    logic [MSQ_W-1:0]        r_msq;
    logic [MAG_W-1:0]        r_m;
    logic [3:0]              r_bit;

    logic [2*MUL_W-1:0]      w_prod;
    logic [MUL_W-1:0]        w_ma, w_mb;
    logic [CNT_W-1:0]        w_n;
    logic signed [A-1:0]     w_a_src;
    logic signed [C2_W-1:0]  w_c_src;
    logic [A-1:0]            w_ua, w_ure, w_uim, w_th;
    logic [C2_W-1:0]         w_uc;
    logic                    w_neg, w_sh17;
    logic [16:0]             w_bias;
    logic [FULL_W:0]         w_full;
    logic [Q_W-1:0]          w_lim, w_qs;
    logic signed [A-1:0]     w_pq;
    logic [A:0]              w_add_a, w_add_b, w_re_sub;
    logic [MAG_W-1:0]        w_t;
    logic signed [PH_W-1:0]  w_phase;
    logic                    w_ph_done;
    t_ph_req                 w_ph_req;

    // saturate to the accumulator range, flag in the top bit
    function automatic logic [A:0] clamp_acc(input logic signed [A+1:0] v);
        logic [A:0] r;
        if (v > ACC_HI) begin
            r = {1'b1, ACC_HI[A-1:0]};
        end else if (v < ACC_LO) begin
            r = {1'b1, ACC_LO[A-1:0]};
        end else begin
            r = {1'b0, v[A-1:0]};
        end
        return r;
    endfunction

    assign w_n = (r_bsz < CNT_W'(BSZ_MIN)) ? CNT_W'(BSZ_MIN)
               : ((r_bsz > CNT_W'(MAX_BLOCK)) ? CNT_W'(MAX_BLOCK) : r_bsz);

    // coefficient product operands
    assign w_a_src = (r_op == OP_REC) ? r_s1 : r_s2;
    assign w_c_src = (r_op == OP_IM) ? C2_W'(r_sine) : r_c2cos;
    assign w_ua    = w_a_src[A-1] ? (~w_a_src + 1'b1) : w_a_src;
    assign w_uc    = w_c_src[C2_W-1] ? (~w_c_src + 1'b1) : w_c_src;
    assign w_neg   = w_a_src[A-1] ^ w_c_src[C2_W-1];
    assign w_sh17  = (r_op == OP_RE);
    // round half up at the q point
    assign w_bias  = w_sh17 ? (w_neg ? 17'd65535 : 17'd65536)
                            : (w_neg ? 17'd32767 : 17'd32768);
    assign w_full  = ((FULL_W+1)'(w_prod[HIW+C2_W-1:0]) << HALF)
                   + (FULL_W+1)'(r_plo) + (FULL_W+1)'(w_bias);
    assign w_lim   = Q_W'({1'b0, {(A-1){1'b1}}}) + Q_W'(w_neg);
    assign w_qs    = (r_q > w_lim) ? w_lim : r_q;
    assign w_pq    = w_neg ? -$signed(A'(w_qs)) : $signed(A'(w_qs));

    assign w_add_a  = clamp_acc((A+2)'(r_x) + (A+2)'(r_pq));
    assign w_add_b  = clamp_acc((A+2)'(r_pq) - (A+2)'(r_s2));
    assign w_re_sub = clamp_acc((A+2)'(r_s1) - (A+2)'(r_pq));

    // magnitude search
    assign w_ure = r_re[A-1] ? (~r_re + 1'b1) : r_re;
    assign w_uim = r_im[A-1] ? (~r_im + 1'b1) : r_im;
    assign w_th  = A'({r_count, 15'b0});
    assign w_t   = r_m | (MAG_W'(1) << r_bit);

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_M_LO: begin
                w_ma = MUL_W'(w_ua[HALF-1:0]);
                w_mb = MUL_W'(w_uc);
            end
            S_M_HI: begin
                w_ma = MUL_W'(w_ua[A-1:HALF]);
                w_mb = MUL_W'(w_uc);
            end
            S_SQ_R: begin
                w_ma = w_ure[MUL_W-1:0];
                w_mb = w_ure[MUL_W-1:0];
            end
            S_SQ_I: begin
                w_ma = w_uim[MUL_W-1:0];
                w_mb = w_uim[MUL_W-1:0];
            end
            S_B_TN: begin
                w_ma = MUL_W'(w_t);
                w_mb = MUL_W'(r_count);
            end
            S_B_SQ: begin
                w_ma = w_prod[MUL_W-1:0];
                w_mb = w_prod[MUL_W-1:0];
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    gbtd_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    assign w_ph_req.start  = (r_state == S_MAG_CHK);
    assign w_ph_req.re_neg = r_re[A-1];
    assign w_ph_req.im_neg = r_im[A-1];

    gbtd_cordic #(.ACC_BITS(ACC_BITS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_ph_req),
        .i_ux    (w_ure),
        .i_uy    (w_uim),
        .o_phase (w_phase),
        .o_done  (w_ph_done)
    );

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_REC;
            r_bsz       <= CNT_W'(256);
            r_c2cos     <= '0;
            r_sine      <= SINE_W'(65536);
            r_s1        <= '0;
            r_s2        <= '0;
            r_count     <= '0;
            r_sat       <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_BLOCK_SIZE: r_bsz   <= i_cfg_data[CNT_W-1:0];
                    CFG_TWO_COS:    r_c2cos <= i_cfg_data;
                    CFG_SINE:       r_sine  <= i_cfg_data[SINE_W-1:0];
                    default: ;
                endcase
            end
            // in S_OUT the result register is refilled below
            if (o_out_valid && i_out_ready && r_state != S_OUT) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_x    <= i_sample;
                        r_last <= i_last;
                        if (r_count < w_n) begin
                            r_op    <= OP_REC;
                            r_state <= S_M_LO;
                        end else if (i_last) begin
                            r_op    <= OP_RE;
                            r_state <= (r_count == '0) ? S_OUT : S_M_LO;
                        end
                    end
                end
                S_M_LO: r_state <= S_M_HI;
                S_M_HI: begin
                    r_plo   <= w_prod[HALF+C2_W-1:0];
                    r_state <= S_M_RND;
                end
                S_M_RND: begin
                    r_q     <= Q_W'(w_full >> (w_sh17 ? 17 : 16));
                    r_state <= S_M_SAT;
                end
                S_M_SAT: begin
                    r_pq <= w_pq;
                    if (r_q > w_lim) begin
                        r_sat <= 1'b1;
                    end
                    case (r_op)
                        OP_REC:  r_state <= S_ADD_A;
                        OP_RE:   r_state <= S_RE_SUB;
                        default: r_state <= S_IM_ST;
                    endcase
                end
                S_ADD_A: begin
                    r_pq <= w_add_a[A-1:0];
                    if (w_add_a[A]) r_sat <= 1'b1;
                    r_state <= S_ADD_B;
                end
                S_ADD_B: begin
                    r_s1    <= w_add_b[A-1:0];
                    r_s2    <= r_s1;
                    r_count <= r_count + 1'b1;
                    if (w_add_b[A]) r_sat <= 1'b1;
                    if (r_last) begin
                        r_op    <= OP_RE;
                        r_state <= S_M_LO;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_RE_SUB: begin
                    r_re <= w_re_sub[A-1:0];
                    if (w_re_sub[A]) r_sat <= 1'b1;
                    r_op    <= OP_IM;
                    r_state <= S_M_LO;
                end
                S_IM_ST: begin
                    r_im    <= r_pq;
                    r_state <= S_MAG_CHK;
                end
                S_MAG_CHK: begin
                    r_bit <= 4'(MAG_W - 1);
                    if (w_ure >= w_th || w_uim >= w_th) begin
                        r_m     <= '1;
                        r_state <= S_PH_WAIT;
                    end else begin
                        r_m     <= '0;
                        r_state <= S_SQ_R;
                    end
                end
                S_SQ_R: r_state <= S_SQ_I;
                S_SQ_I: begin
                    r_msq   <= w_prod[MSQ_W-1:0];
                    r_state <= S_SQ_SUM;
                end
                S_SQ_SUM: begin
                    r_msq   <= r_msq + w_prod[MSQ_W-1:0];
                    r_state <= S_B_TN;
                end
                S_B_TN: r_state <= S_B_SQ;
                S_B_SQ: r_state <= S_B_CMP;
                S_B_CMP: begin
                    // keep the bit while (t*n)^2 <= 4*(re^2 + im^2)
                    if (w_prod <= (2*MUL_W)'({r_msq, 2'b00})) begin
                        r_m <= w_t;
                    end
                    if (r_bit == '0) begin
                        r_state <= S_PH_WAIT;
                    end else begin
                        r_bit   <= r_bit - 4'd1;
                        r_state <= S_B_TN;
                    end
                end
                S_PH_WAIT: begin
                    if (w_ph_done) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid    <= 1'b1;
                        o_samples_used <= r_count;
                        if (r_count == '0) begin
                            o_magnitude   <= '0;
                            o_phase       <= '0;
                            o_empty_block <= 1'b1;
                            o_overflow    <= 1'b0;
                        end else begin
                            o_magnitude   <= r_m;
                            o_phase       <= w_phase;
                            o_empty_block <= 1'b0;
                            o_overflow    <= r_sat;
                        end
                        r_s1    <= '0;
                        r_s2    <= '0;
                        r_count <= '0;
                        r_sat   <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/gbtd_mul.sv]
// shared unsigned 32x32 multiplier with registered product
`timescale 1ns / 1ps
`default_nettype none

module gbtd_mul
    import gbtd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic [MUL_W-1:0]     i_a,
    input  wire logic [MUL_W-1:0]     i_b,
    output logic      [2*MUL_W-1:0]   o_p
);

    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end

endmodule

`default_nettype wire

[rtl/core/gbtd_cordic.sv]
// iterative phase unit: normalize one bit a cycle, then fifteen cordic steps
`timescale 1ns / 1ps
`default_nettype none

module gbtd_cordic
    import gbtd_pkg::*;
#(
    parameter int ACC_BITS = 48
)
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_ph_req              i_req,
    input  wire logic [ACC_BITS-1:0]  i_ux,
    input  wire logic [ACC_BITS-1:0]  i_uy,
    output logic signed [PH_W-1:0]    o_phase,
    output logic                      o_done
);

    localparam int XW = 34;
    localparam logic [ACC_BITS-1:0] NORM_HI = ACC_BITS'(1) << 30;
    localparam logic [ACC_BITS-1:0] NORM_LO = ACC_BITS'(1) << 29;

    typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER, C_FIN} t_cstate;

    t_cstate                r_state;
    logic [ACC_BITS-1:0]    r_ux, r_uy;
    logic signed [XW-1:0]   r_x, r_y;
    logic signed [17:0]     r_z;
    logic [3:0]             r_k;
    logic                   r_re_neg, r_im_neg;

    logic [ACC_BITS-1:0]    w_mx;
    logic signed [XW-1:0]   w_dx, w_dy;
    logic signed [17:0]     w_at, w_zc, w_zm, w_zf;

    assign w_mx = (r_ux > r_uy) ? r_ux : r_uy;
    assign w_dx = r_y >>> r_k;
    assign w_dy = r_x >>> r_k;
    assign w_at = $signed({4'b0000, atan_step(r_k)});
    assign w_zc = r_z[17] ? 18'sd0 : ((r_z > 18'sd16384) ? 18'sd16384 : r_z);
    assign w_zm = r_re_neg ? (18'sd32768 - w_zc) : w_zc;
    assign w_zf = r_im_neg ? -w_zm : w_zm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            o_done  <= 1'b0;
        end else if (i_req.start) begin
            r_ux     <= i_ux;
            r_uy     <= i_uy;
            r_re_neg <= i_req.re_neg;
            r_im_neg <= i_req.im_neg;
            o_done   <= 1'b0;
            r_state  <= C_NORM;
        end else begin
            case (r_state)
                C_NORM: begin
                    if (w_mx == '0) begin
                        o_phase <= '0;
                        o_done  <= 1'b1;
                        r_state <= C_IDLE;
                    end else if (w_mx >= NORM_HI) begin
                        r_ux <= r_ux >> 1;
                        r_uy <= r_uy >> 1;
                    end else if (w_mx < NORM_LO) begin
                        r_ux <= r_ux << 1;
                        r_uy <= r_uy << 1;
                    end else begin
                        r_x     <= $signed(XW'(r_ux));
                        r_y     <= $signed(XW'(r_uy));
                        r_z     <= '0;
                        r_k     <= '0;
                        r_state <= C_ITER;
                    end
                end
                C_ITER: begin
                    if (!r_y[XW-1]) begin
                        r_x <= r_x + w_dx;
                        r_y <= r_y - w_dy;
                        r_z <= r_z + w_at;
                    end else begin
                        r_x <= r_x - w_dx;
                        r_y <= r_y + w_dy;
                        r_z <= r_z - w_at;
                    end
                    if (r_k == 4'(CORDIC_N - 1)) begin
                        r_state <= C_FIN;
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end
                C_FIN: begin
                    // an angle of pi wraps to the most negative code
                    o_phase <= w_zf[PH_W-1:0];
                    o_done  <= 1'b1;
                    r_state <= C_IDLE;
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/gbtd_checker.sv]
// port-level checks of the goertzel tone detector and their bind
`timescale 1ns / 1ps
`default_nettype none

module gbtd_checker
    import gbtd_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    o_in_ready,
    input wire logic                    o_out_valid,
    input wire logic                    i_out_ready,
    input wire logic [MAG_W-1:0]        o_magnitude,
    input wire logic [PH_W-1:0]         o_phase,
    input wire logic [CNT_W-1:0]        o_samples_used,
    input wire logic                    o_empty_block,
    input wire logic                    o_overflow
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_magnitude)
            && $stable(o_phase) && $stable(o_samples_used) && $stable(o_overflow))
        else $error("result changed while stalled");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_empty_block |-> o_magnitude == '0 && o_phase == '0
            && o_samples_used == '0 && !o_overflow)
        else $error("empty block with nonzero fields");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_empty_block |-> o_samples_used != '0
            && o_samples_used <= CNT_W'(MAX_BLOCK))
        else $error("samples used out of range");

    // a result only appears after the block stopped taking samples
    a_busy_before_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result without end of block processing");

endmodule

bind goertzel_block_tone_detector gbtd_checker u_gbtd_checker (.*);

`default_nettype wire
